// ----- hdl/fgpt_pkg.sv -----
// shared types and constants for the frame gateway policy table
`default_nettype none
package fgpt_pkg;

  localparam int unsigned WINDOW_MS = 1000;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    CMD_EVAL   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  // lowest of the unused command codes, which do nothing
  localparam logic [2:0] CMD_SPARE = 3'd5;

  localparam logic [2:0] ACT_DENY      = 3'd1;
  localparam logic [2:0] ACT_RATE      = 3'd2;
  localparam logic [2:0] ACT_LOG_ONLY  = 3'd4;
  localparam logic [2:0] ACT_REDIRECT  = 3'd5;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  channel_type;
    logic [7:0]  channel_num;
    logic [31:0] frame_ident;
    logic [31:0] now_ms;
    logic [2:0]  rule_action;
    logic [15:0] frame_quota;
    logic [7:0]  redirect_type;
    logic [7:0]  redirect_num;
    logic [31:0] redirect_frame;
  } req_t;

  typedef struct packed {
    logic        verdict;
    logic [7:0]  out_channel_type;
    logic [7:0]  out_channel_num;
    logic [31:0] out_frame_ident;
    logic        log_pulse;
    logic [1:0]  op_status;
    logic [4:0]  rule_count;
    logic [31:0] deny_total;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/fgpt_front.sv -----
// front end: takes requests and holds them in a short queue
`default_nettype none
module fgpt_front import fgpt_pkg::*; (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic start,
  input  wire  req_t req_in,
  output logic       busy,
  output logic       q_valid,
  output req_t       q_req,
  input  wire  logic q_pop
);
  // two-entry queue
  req_t       slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign push    = start && !busy;
  assign busy    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_req   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= req_in;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/fgpt_back.sv -----
// back end: rule table, lookup and command execution
`default_nettype none
module fgpt_back import fgpt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic log_enable,
  input  wire  logic q_valid,
  input  wire  req_t q_req,
  output logic       q_pop,
  output logic       res_valid,
  output res_t       res
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC} state_t;
  state_t state;

  logic [TABLE_DEPTH-1:0] valid;
  logic [47:0] key_r  [TABLE_DEPTH];
  logic [2:0]  act_r  [TABLE_DEPTH];
  logic [15:0] lim_r  [TABLE_DEPTH];
  logic [47:0] red_r  [TABLE_DEPTH];
  logic [16:0] wcnt   [TABLE_DEPTH];
  logic [31:0] wstart [TABLE_DEPTH];
  logic [31:0] deny_counter;
  logic [CW-1:0] count;

  req_t        cur;
  logic        hit, has_free;
  logic [IW-1:0] hit_idx, free_idx;
  logic [IW-1:0] wr_idx;

  // parallel key compare and registered first-match results
  logic [47:0] cur_key;
  logic        hit_c, free_c;
  logic [IW-1:0] hit_ic, free_ic;
  assign cur_key = {cur.channel_type, cur.channel_num, cur.frame_ident};

  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; hit_ic = '0; free_ic = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (valid[i] && key_r[i] == cur_key) begin
        hit_c = 1'b1; hit_ic = IW'(i);
      end
      if (!valid[i]) begin
        free_c = 1'b1; free_ic = IW'(i);
      end
    end
  end

  // replace the matching rule, else take the first free slot
  assign wr_idx = hit ? hit_idx : free_idx;

  // window restart test per entry
  function automatic logic win_expired(input logic [31:0] now, input logic [31:0] st);
    logic [31:0] d;
    d = now - st;
    return (d >= 32'(WINDOW_MS)) || (now < st);
  endfunction

  // evaluation of the matched rule
  logic        e_exp;
  logic [16:0] e_cnt;
  logic        e_deny, e_pulse, e_red;
  always_comb begin
    e_exp = win_expired(cur.now_ms, wstart[hit_idx]);
    e_cnt = e_exp ? 17'd0 : wcnt[hit_idx];
    if (e_cnt != COUNT_MAX) e_cnt = e_cnt + 17'd1;
    e_deny = 1'b0; e_pulse = 1'b0; e_red = 1'b0;
    if (hit) begin
      case (act_r[hit_idx])
        ACT_RATE:     e_deny = (lim_r[hit_idx] == 16'd0) || (e_cnt > {1'b0, lim_r[hit_idx]});
        ACT_DENY:     begin e_deny = 1'b1; e_pulse = log_enable; end
        ACT_LOG_ONLY: e_pulse = log_enable;
        ACT_REDIRECT: e_red = 1'b1;
        default:      ;
      endcase
    end
  end

  logic [CW-1:0] count_next;
  always_comb begin
    count_next = count;
    case (cur.command)
      CMD_ADD:    if (!hit && has_free) count_next = count + CW'(1);
      CMD_REMOVE: if (hit) count_next = count - CW'(1);
      CMD_CLEAR:  count_next = '0;
      default:    ;
    endcase
  end

  // result of the request being executed
  res_t res_next;
  always_comb begin
    res_next           = '0;
    res_next.op_status = ST_DONE;
    {res_next.out_channel_type, res_next.out_channel_num, res_next.out_frame_ident} = cur_key;
    case (cur.command)
      CMD_EVAL: begin
        res_next.verdict   = e_deny;
        res_next.log_pulse = e_pulse;
        if (e_red) begin
          {res_next.out_channel_type, res_next.out_channel_num, res_next.out_frame_ident} =
            red_r[hit_idx];
        end
      end
      CMD_ADD:    if (!hit && !has_free) res_next.op_status = ST_FULL;
      CMD_REMOVE: if (!hit) res_next.op_status = ST_NOTFOUND;
      default:    ;
    endcase
    res_next.rule_count = 5'(count_next);
    res_next.deny_total = (cur.command == CMD_CLEAR) ? 32'd0 :
                          (cur.command == CMD_EVAL && e_deny) ? deny_counter + 32'd1 :
                          deny_counter;
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      count        <= '0;
      deny_counter <= '0;
      res_valid    <= 1'b0;
    end else begin
      res_valid <= (state == S_EXEC);
      case (state)
        S_IDLE: if (q_valid) begin
          cur   <= q_req;
          state <= S_LOOK;
        end
        S_LOOK: begin
          hit <= hit_c; hit_idx <= hit_ic;
          has_free <= free_c; free_idx <= free_ic;
          state <= S_EXEC;
        end
        S_EXEC: begin
          res <= res_next;
          case (cur.command)
            CMD_EVAL: begin
              if (hit && act_r[hit_idx] == ACT_RATE && lim_r[hit_idx] != 16'd0) begin
                wcnt[hit_idx] <= e_cnt;
                if (e_exp) wstart[hit_idx] <= cur.now_ms;
              end
              if (e_deny) deny_counter <= deny_counter + 32'd1;
            end
            CMD_ADD: begin
              if (hit || has_free) begin
                key_r[wr_idx]  <= cur_key;
                act_r[wr_idx]  <= cur.rule_action;
                lim_r[wr_idx]  <= cur.frame_quota;
                red_r[wr_idx]  <= {cur.redirect_type, cur.redirect_num, cur.redirect_frame};
                wcnt[wr_idx]   <= '0;
                wstart[wr_idx] <= '0;
                valid[wr_idx]  <= 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (hit) valid[hit_idx] <= 1'b0;
            end
            CMD_CLEAR: begin
              valid        <= '0;
              deny_counter <= '0;
            end
            CMD_TICK: begin
              for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (valid[i] && win_expired(cur.now_ms, wstart[i])) begin
                  wstart[i] <= cur.now_ms;
                  wcnt[i]   <= '0;
                end
              end
            end
            default: ;
          endcase
          count <= count_next;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/frame_gateway_policy_table.sv -----
// top level of the frame gateway policy table
// Usage:
//   A request (command plus key, time and rule operands) is taken at a rising
//   edge with start high and busy low. Commands: evaluate, add, remove, clear,
//   tick. Each request gives exactly one result on the result port, marked by
//   done for one cycle; the receiver cannot stall it.
//   With the back end idle, an accepted request passes the queue pop, the key
//   compare across all rules and the execute into the result register, then
//   done goes high. One request is worked at a time by the back end, so it
//   pops the next only once the last has left execute; the two-entry queue lets
//   the front end take up to two requests ahead.
//   Tick restarts every expired rate window in the execute state.
//   log_enable is written through the APB port at address 0.
//   Reset (synchronous rst) empties the table and queue, zeroes the deny
//   count and clears log_enable.
`default_nettype none
module frame_gateway_policy_table import fgpt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        start,
  output logic              busy,
  input  wire  req_t        request,
  output logic              done,
  output res_t              result,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic        paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic log_enable;
  logic q_valid, q_pop;
  req_t q_req;

  // configuration register
  assign pready = 1'b1;
  assign prdata = {31'd0, log_enable};
  always_ff @(posedge clk) begin
    if (rst) log_enable <= 1'b0;
    else if (psel && penable && pwrite && pready && !paddr) log_enable <= pwdata[0];
  end

  fgpt_front u_front (
    .clk, .rst, .start, .req_in(request), .busy,
    .q_valid, .q_req, .q_pop
  );

  fgpt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .log_enable, .q_valid, .q_req, .q_pop,
    .res_valid(done), .res(result)
  );

  // checks
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(start && !busy)) else $error("accepted while busy");
  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> result.rule_count <= 5'(TABLE_DEPTH)) else $error("rule count overflow");
  a_deny_verdict: assert property (@(posedge clk) disable iff (rst)
    done && result.verdict |-> result.op_status == ST_DONE) else $error("bad deny status");
endmodule
`default_nettype wire

// ----- verif/fgpt_checker.sv -----
// checker for the frame gateway policy table: predicts and compares every result
`default_nettype none
module fgpt_checker import fgpt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire req_t        request,
  input  wire logic        done,
  input  wire res_t        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               errors,
  output int               pending
);

  // predicted copy of the table
  logic        log_on;
  logic        rule_valid [DEPTH];
  logic [47:0] rule_key   [DEPTH];
  logic [2:0]  rule_act   [DEPTH];
  logic [15:0] rule_limit [DEPTH];
  logic [47:0] rule_redir [DEPTH];
  logic [16:0] win_count  [DEPTH];
  logic [31:0] win_start  [DEPTH];
  logic [31:0] denies;
  res_t        verdicts_due [$];

  function automatic int lookup(logic [47:0] k);
    for (int i = 0; i < DEPTH; i++)
      if (rule_valid[i] && rule_key[i] == k) return i;
    return -1;
  endfunction

  // restart the rate window once it has run out or time went backwards
  task automatic roll_window(int i, logic [31:0] now);
    logic [31:0] age;
    age = now - win_start[i];
    if (age >= WINDOW_MS || now < win_start[i]) begin
      win_start[i] = now;
      win_count[i] = '0;
    end
  endtask

  task automatic apply_request(req_t r, output res_t e);
    logic [47:0] k;
    logic [47:0] out_key;
    int          i;
    int          n;
    k = {r.channel_type, r.channel_num, r.frame_ident};
    out_key = k;
    e = '0;
    case (r.command)
      CMD_EVAL: begin
        i = lookup(k);
        if (i >= 0) begin
          if (rule_act[i] == ACT_RATE && rule_limit[i] != 0) begin
            roll_window(i, r.now_ms);
            if (win_count[i] != COUNT_MAX) win_count[i]++;
            if (win_count[i] > {1'b0, rule_limit[i]}) begin
              denies++;
              e.verdict = 1'b1;
            end
          end else if (rule_act[i] == ACT_DENY) begin
            denies++;
            e.verdict = 1'b1;
            e.log_pulse = log_on;
          end else if (rule_act[i] == ACT_LOG_ONLY) begin
            e.log_pulse = log_on;
          end else if (rule_act[i] == ACT_REDIRECT) begin
            out_key = rule_redir[i];
          end else if (rule_act[i] == ACT_RATE) begin
            // zero limit always denies
            denies++;
            e.verdict = 1'b1;
          end
        end
      end
      CMD_ADD: begin
        i = lookup(k);
        if (i < 0)
          for (int j = DEPTH - 1; j >= 0; j--)
            if (!rule_valid[j]) i = j;
        if (i < 0) begin
          e.op_status = ST_FULL;
        end else begin
          rule_valid[i] = 1'b1;
          rule_key[i]   = k;
          rule_act[i]   = r.rule_action;
          rule_limit[i] = r.frame_quota;
          rule_redir[i] = {r.redirect_type, r.redirect_num, r.redirect_frame};
          win_count[i]  = '0;
          win_start[i]  = '0;
        end
      end
      CMD_REMOVE: begin
        i = lookup(k);
        if (i < 0) e.op_status = ST_NOTFOUND;
        else rule_valid[i] = 1'b0;
      end
      CMD_CLEAR: begin
        for (int j = 0; j < DEPTH; j++) rule_valid[j] = 1'b0;
        denies = '0;
      end
      CMD_TICK: begin
        for (int j = 0; j < DEPTH; j++)
          if (rule_valid[j]) roll_window(j, r.now_ms);
      end
      default: ;
    endcase
    n = 0;
    for (int j = 0; j < DEPTH; j++) if (rule_valid[j]) n++;
    e.out_channel_type = out_key[47:40];
    e.out_channel_num  = out_key[39:32];
    e.out_frame_ident  = out_key[31:0];
    e.rule_count       = n[4:0];
    e.deny_total       = denies;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  // watch requests, register writes and results at each rising edge
  always @(posedge clk) begin
    res_t e;
    res_t want;
    if (rst) begin
      log_on = 1'b0;
      denies = '0;
      for (int j = 0; j < DEPTH; j++) rule_valid[j] = 1'b0;
      verdicts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 1'b0) log_on = pwdata[0];
      if (start && !busy) begin
        apply_request(request, e);
        verdicts_due = {verdicts_due, e};
      end
      if (done) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result with nothing expected, got %p", $time, result);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("verdict", want.verdict, result.verdict);
          check_field("out_channel_type", want.out_channel_type, result.out_channel_type);
          check_field("out_channel_num", want.out_channel_num, result.out_channel_num);
          check_field("out_frame_ident", want.out_frame_ident, result.out_frame_ident);
          check_field("log_pulse", want.log_pulse, result.log_pulse);
          check_field("op_status", want.op_status, result.op_status);
          check_field("rule_count", want.rule_count, result.rule_count);
          check_field("deny_total", want.deny_total, result.deny_total);
        end
      end
    end
    pending = verdicts_due.size();
  end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// stimulus and verdict for the frame gateway policy table
`default_nettype none
module testbench;
  import fgpt_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int KEYS = 24;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        done;
  res_t        result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic        paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          quiet;
  logic        bursty;
  logic [31:0] clock_ms;
  logic [47:0] key_pool [KEYS];

  frame_gateway_policy_table dut (
    .clk, .rst, .start, .busy, .request, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  fgpt_checker chk (
    .clk, .rst, .start, .busy, .request, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // give up once nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // hand one request over and wait for it to be taken
  task automatic issue(req_t r);
    if (bursty && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 17)) @(negedge clk);
    start = 1'b1;
    request = r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_log_enable(logic v);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = 1'b0;
    pwdata = {$urandom_range(0, 32'h7FFF_FFFF), 1'b0} | {31'd0, v};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic req_t make_req(logic [2:0] c, logic [47:0] k, logic [2:0] a,
                                    logic [15:0] lim);
    req_t r;
    r.command = c;
    {r.channel_type, r.channel_num, r.frame_ident} = k;
    r.now_ms = clock_ms;
    r.rule_action = a;
    r.frame_quota = lim;
    r.redirect_type = 8'($urandom);
    r.redirect_num = 8'($urandom);
    r.redirect_frame = $urandom;
    return r;
  endfunction

  // mostly commands on a small key pool so rules get hit, with some noise
  function automatic req_t random_req();
    req_t        r;
    logic [47:0] k;
    logic [2:0]  c;
    int          pick;
    int          step;
    step = $urandom_range(0, 99);
    if (step < 3) clock_ms = $urandom;
    else if (step < 6) clock_ms = clock_ms - $urandom_range(1, 3000);
    else clock_ms = clock_ms + $urandom_range(0, 450);
    pick = $urandom_range(0, 99);
    if (pick < 50) c = CMD_EVAL;
    else if (pick < 72) c = CMD_ADD;
    else if (pick < 84) c = CMD_REMOVE;
    else if (pick < 94) c = CMD_TICK;
    else if (pick < 96) c = CMD_CLEAR;
    else c = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) k = 48'({$urandom, $urandom});
    else k = key_pool[$urandom_range(0, KEYS - 1)];
    r = make_req(c, k, 3'($urandom_range(0, 7)),
                 $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4)));
    if ($urandom_range(0, 3) == 0) r.now_ms = $urandom;
    return r;
  endfunction

  initial begin
    req_t r;
    rst = 1'b1; start = 1'b0; request = '0; bursty = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 1'b0; pwdata = '0;
    quiet = 0;
    clock_ms = 32'd5000;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEYS; i++) key_pool[i] = 48'({$urandom, $urandom});
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: one rule of each action, then hits on each
    for (int a = 0; a < 8; a++)
      issue(make_req(CMD_ADD, key_pool[a], a[2:0], a == int'(ACT_RATE) ? 16'd2 : 16'hFFFF));
    issue(make_req(CMD_ADD, key_pool[8], ACT_RATE, 16'd0));
    for (int a = 0; a < 9; a++) issue(make_req(CMD_EVAL, key_pool[a], '0, '0));
    issue(make_req(CMD_EVAL, key_pool[2], '0, '0));
    issue(make_req(CMD_EVAL, key_pool[2], '0, '0));
    clock_ms = 32'd3;
    issue(make_req(CMD_TICK, key_pool[9], '0, '0));
    issue(make_req(CMD_EVAL, key_pool[2], '0, '0));
    issue(make_req(CMD_REMOVE, key_pool[20], '0, '0));
    issue(make_req(CMD_REMOVE, key_pool[0], '0, '0));
    issue(make_req(CMD_SPARE, key_pool[1], '0, '0));

    // fill the table, overflow it, then replace while full
    write_log_enable(1'b1);
    for (int i = 0; i < 18; i++)
      issue(make_req(CMD_ADD, key_pool[i], ACT_DENY, '0));
    issue(make_req(CMD_ADD, key_pool[3], ACT_LOG_ONLY, '0));
    issue(make_req(CMD_EVAL, key_pool[3], '0, '0));
    issue(make_req(CMD_EVAL, key_pool[4], '0, '0));
    issue(make_req(CMD_CLEAR, key_pool[1], '0, '0));

    // random phases with the logging switched between them
    bursty = 1'b1;
    for (int i = 0; i < 900; i++) begin
      if (i == 300) write_log_enable(1'b0);
      if (i == 600) write_log_enable(1'b1);
      if (i == 780) bursty = 1'b0;
      r = random_req();
      issue(r);
    end

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
